### rtl/core/pta_pkg.sv
// shared types, codes and helpers of the pi throttle controller
`default_nettype none

package pta_pkg;

  localparam int AccW  = 64;
  localparam int IntW  = 40;
  localparam int ErrW  = 17;
  localparam int MulAW = 17;
  localparam int MulBW = 25;
  localparam int ProdW = MulAW + MulBW;

  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic signed [IntW-1:0]  integ_t;
  typedef logic signed [ProdW-1:0] prod_t;

  localparam logic [15:0] OneQ15 = 16'd32768;

  localparam acc_t IntegMaxExt = 64'sd549755813887;
  localparam acc_t IntegMinExt = -64'sd549755813888;

  typedef enum logic [1:0] {
    CS_NONE = 2'd0,
    CS_HIGH = 2'd1,
    CS_LOW  = 2'd2
  } clamp_e;

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_WINDUP_GAIN  = 3'd2,
    REG_FFWD_GAIN    = 3'd3,
    REG_THROTTLE_MAX = 3'd4
  } cfg_idx_e;

  // saturate a wide value to the integrator range
  function automatic integ_t sat_integ(acc_t x);
    integ_t r;
    if (x > IntegMaxExt) begin
      r = IntegMaxExt[IntW-1:0];
    end else if (x < IntegMinExt) begin
      r = IntegMinExt[IntW-1:0];
    end else begin
      r = x[IntW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pi_throttle_antiwindup_top.sv
// velocity pi throttle controller with feed-forward and back-calculation anti-windup
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: vel_err_in, ref_speed, meas_speed,
//           |     |                               |        step_time; tuser: func
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: throttle, clamp_state
//  cfg      | in  | cfg_we_i (no wait)            | cfg_idx_i, cfg_data_i
//
// a beat runs from accept through the sequencer steps back to idle before the next accept;
// a clamped command adds the windup steps; the pace is set by the single 17x25 multiplier
// that the sequencer reuses for every product (split partial products for the wide ones)
// and the accumulator behind it
// reset clears the integrator, the sequencer and the output valid; gains reset to zero
// and the throttle limit to 1.0
// a result waits in the output register while the next beat is taken in; the sequencer
// holds in its last step only if that register is still full
`default_nettype none

module pi_throttle_antiwindup_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] vel_err_in, [31:16] ref_speed, [47:32] meas_speed, [63:48] step_time
  input  wire logic [63:0] s_axis_tdata,
  // [0] func
  input  wire logic        s_axis_tuser,
  // master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] throttle, [17:16] clamp_state, [23:18] zero
  output logic [23:0]      m_axis_tdata,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  import pta_pkg::*;

  // sequencer steps, at most one product issued per step
  typedef enum logic [3:0] {
    ST_IDLE,  // wait for a beat
    ST_DT,    // err * dt
    ST_P,     // prop * err, integrator += round(err * dt)
    ST_FF,    // ffwd * ref, u = prop term
    ST_IL,    // integ_gain * integ low half, u += ff term
    ST_IH,    // integ_gain * integ high half, u += low half
    ST_CMP,   // u += high half
    ST_EVAL,  // clamp decision, excess
    ST_XRND,  // excess rounded to q.16
    ST_WL,    // windup * excess low half
    ST_WH,    // windup * excess high half
    ST_WC,    // correction sum
    ST_WRND,  // correction rounded
    ST_WSUB,  // integrator -= correction
    ST_DONE   // hand result to the output register
  } state_e;

  state_e state_q;

  // configuration registers
  logic [15:0] prop_gain_q, integ_gain_q, windup_gain_q, ffwd_gain_q, throttle_max_q;

  // working registers
  logic                   func_q;
  logic signed [ErrW-1:0] err_q;
  logic signed [15:0]     ref_q;
  logic [15:0]            dt_q;
  prod_t                  prod_q;
  acc_t                   acc_q;
  integ_t                 integ_q;
  logic [15:0]            res_thr_q;
  clamp_e                 res_cs_q;

  // output register
  logic                   out_valid_q;
  logic [15:0]            out_thr_q;
  clamp_e                 out_cs_q;

  // input unpacking
  logic signed [15:0]     in_vel, in_ref, in_meas;
  logic signed [ErrW-1:0] in_err;

  // shared multiplier
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  prod_t                   mul_p;

  // datapath helpers
  acc_t        prod_ext, integ_ext, dt_rnd, lim_ext, thr_rnd, half_rnd;
  logic [15:0] lim_eff;

  assign in_vel  = $signed(s_axis_tdata[15:0]);
  assign in_ref  = $signed(s_axis_tdata[31:16]);
  assign in_meas = $signed(s_axis_tdata[47:32]);
  assign in_err  = s_axis_tuser ? ({in_ref[15], in_ref} - {in_meas[15], in_meas})
                                : {in_vel[15], in_vel};

  // operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DT: begin
        mul_a = err_q;
        mul_b = $signed({9'd0, dt_q});
      end
      ST_P: begin
        mul_a = $signed({1'b0, prop_gain_q});
        mul_b = $signed({{(MulBW-ErrW){err_q[ErrW-1]}}, err_q});
      end
      ST_FF: begin
        // no feed-forward term when the error came in directly
        mul_a = func_q ? $signed({1'b0, ffwd_gain_q}) : '0;
        mul_b = $signed({{(MulBW-16){ref_q[15]}}, ref_q});
      end
      ST_IL: begin
        mul_a = $signed({1'b0, integ_gain_q});
        mul_b = $signed({5'd0, integ_q[19:0]});
      end
      ST_IH: begin
        mul_a = $signed({1'b0, integ_gain_q});
        mul_b = $signed({{5{integ_q[39]}}, integ_q[39:20]});
      end
      ST_WL: begin
        mul_a = $signed({1'b0, windup_gain_q});
        mul_b = $signed({1'b0, acc_q[23:0]});
      end
      ST_WH: begin
        mul_a = $signed({1'b0, windup_gain_q});
        mul_b = $signed({acc_q[47], acc_q[47:24]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign prod_ext  = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign integ_ext = {{(AccW-IntW){integ_q[IntW-1]}}, integ_q};
  assign dt_rnd    = (prod_ext + 64'sd128) >>> 8;
  assign lim_eff   = (throttle_max_q > OneQ15) ? OneQ15 : throttle_max_q;
  assign lim_ext   = $signed({35'd0, lim_eff, 13'd0});
  assign thr_rnd   = (acc_q + 64'sd4096) >>> 13;
  assign half_rnd  = (acc_q + 64'sd2048) >>> 12;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= '0;
      integ_gain_q   <= '0;
      windup_gain_q  <= '0;
      ffwd_gain_q    <= '0;
      throttle_max_q <= OneQ15;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:    prop_gain_q    <= cfg_data_i;
        REG_INTEG_GAIN:   integ_gain_q   <= cfg_data_i;
        REG_WINDUP_GAIN:  windup_gain_q  <= cfg_data_i;
        REG_FFWD_GAIN:    ffwd_gain_q    <= cfg_data_i;
        REG_THROTTLE_MAX: throttle_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a claimed result frees the register unless the last step refills it now
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            func_q  <= s_axis_tuser;
            err_q   <= in_err;
            ref_q   <= in_ref;
            dt_q    <= s_axis_tdata[63:48];
            state_q <= ST_DT;
          end
        end
        ST_DT: begin
          prod_q  <= mul_p;
          acc_q   <= '0;
          state_q <= ST_P;
        end
        ST_P: begin
          prod_q  <= mul_p;
          integ_q <= sat_integ(integ_ext + dt_rnd);
          state_q <= ST_FF;
        end
        ST_FF: begin
          prod_q  <= mul_p;
          acc_q   <= acc_q + (prod_ext <<< 8);
          state_q <= ST_IL;
        end
        ST_IL: begin
          prod_q  <= mul_p;
          acc_q   <= acc_q + (prod_ext <<< 8);
          state_q <= ST_IH;
        end
        ST_IH: begin
          prod_q  <= mul_p;
          acc_q   <= acc_q + prod_ext;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          acc_q   <= acc_q + (prod_ext <<< 20);
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (acc_q > lim_ext) begin
            // above the limit: throttle sits at the limit, excess is u - limit
            res_thr_q <= lim_eff;
            res_cs_q  <= CS_HIGH;
            acc_q     <= acc_q - lim_ext;
            state_q   <= ST_XRND;
          end else if (acc_q[AccW-1]) begin
            // negative command: excess is u itself
            res_thr_q <= '0;
            res_cs_q  <= CS_LOW;
            state_q   <= ST_XRND;
          end else begin
            res_thr_q <= thr_rnd[15:0];
            res_cs_q  <= CS_NONE;
            state_q   <= ST_DONE;
          end
        end
        ST_XRND: begin
          acc_q   <= half_rnd;
          state_q <= ST_WL;
        end
        ST_WL: begin
          prod_q  <= mul_p;
          state_q <= ST_WH;
        end
        ST_WH: begin
          prod_q  <= mul_p;
          acc_q   <= prod_ext;
          state_q <= ST_WC;
        end
        ST_WC: begin
          acc_q   <= acc_q + (prod_ext <<< 24);
          state_q <= ST_WRND;
        end
        ST_WRND: begin
          acc_q   <= half_rnd;
          state_q <= ST_WSUB;
        end
        ST_WSUB: begin
          integ_q <= sat_integ(integ_ext - acc_q);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // wait only while the previous result is still unclaimed
          if (!out_valid_q || m_axis_tready) begin
            out_thr_q   <= res_thr_q;
            out_cs_q    <= res_cs_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_cs_q, out_thr_q};

endmodule

`default_nettype wire

### tb/pi_throttle_antiwindup_top_tb.sv
`timescale 1ns / 1ps
// self-checking stream testbench of the pi throttle controller with a bit-exact predictor
module pi_throttle_antiwindup_top_tb;
  import pta_pkg::*;

  // integrator range, Q24.16 in 40 bits
  localparam longint IntegHi = 64'sd549755813887;
  localparam longint IntegLo = -64'sd549755813888;

  localparam int RandPhases   = 6;
  localparam int PhaseItems   = 290;
  // covers any tail of the sequencer, also that of a clamped beat
  localparam int SettleCycles = 24;
  localparam int HoldCycles   = 300;
  localparam int PrintCap     = 100;

  // one control update as offered on the slave side
  typedef struct {
    logic        func;
    logic [15:0] vel_err;
    logic [15:0] ref_speed;
    logic [15:0] meas_speed;
    logic [15:0] step_time;
  } ctl_item_t;

  // one throttle command as expected on the master side
  typedef struct {
    logic [15:0] throttle;
    clamp_e      clamp;
  } throttle_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [15:0] vel_err_in, [31:16] ref_speed, [47:32] meas_speed, [63:48] step_time
  logic [63:0] s_axis_tdata = '0;
  // [0] func
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] throttle, [17:16] clamp_state, [23:18] zero
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  // items waiting to be offered, and commands waiting to come out
  ctl_item_t      item_q[$];
  throttle_beat_t throttle_q[$];

  // controller copy: register values and integrator
  logic [15:0] kp      = '0;
  logic [15:0] ki      = '0;
  logic [15:0] kaw     = '0;
  logic [15:0] kff     = '0;
  logic [15:0] thr_max = OneQ15;
  longint      integ_state = 0;

  int          errors = 0;
  int          beats_in = 0;
  int unsigned tx_gap, tx_calm, rx_stall, rx_calm;
  int          hold_left, hold_at;
  logic        rx_hold = 1'b0;
  throttle_beat_t want;

  pi_throttle_antiwindup_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clip_integ(longint x);
    if (x > IntegHi) return IntegHi;
    if (x < IntegLo) return IntegLo;
    return x;
  endfunction

  // round half toward +inf, then floor shift
  function automatic longint round_half_up(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // advances the integrator copy and returns the command for one update
  function automatic throttle_beat_t predict_throttle(ctl_item_t it);
    longint         err, ff, u, lim, excess, dt, corr;
    logic [15:0]    tmax;
    throttle_beat_t res;
    dt = longint'(it.step_time);
    ff = 0;
    if (it.func) begin
      err = longint'($signed(it.ref_speed)) - longint'($signed(it.meas_speed));
      ff  = longint'(kff) * longint'($signed(it.ref_speed)) * 256;
    end else begin
      err = longint'($signed(it.vel_err));
    end
    integ_state = clip_integ(integ_state + round_half_up(err * dt, 8));
    // command in Q.28
    u = longint'(kp) * err * 256 + longint'(ki) * integ_state + ff;
    // a limit above one acts as one
    tmax = (thr_max > OneQ15) ? OneQ15 : thr_max;
    lim  = longint'(tmax) * 8192;
    excess = 0;
    res.clamp = CS_NONE;
    if (u > lim) begin
      excess = u - lim;
      res.clamp = CS_HIGH;
      res.throttle = tmax;
    end else if (u < 0) begin
      excess = u;
      res.clamp = CS_LOW;
      res.throttle = '0;
    end else begin
      res.throttle = 16'(round_half_up(u, 13));
    end
    // back-calculation: bleed the excess out of the integrator
    if (res.clamp != CS_NONE) begin
      corr = round_half_up(longint'(kaw) * round_half_up(excess, 12), 12);
      integ_state = clip_integ(integ_state - corr);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic ctl_item_t mk_item(logic f, logic [15:0] e, logic [15:0] r,
                                        logic [15:0] m, logic [15:0] dt);
    ctl_item_t it;
    it.func = f;
    it.vel_err = e;
    it.ref_speed = r;
    it.meas_speed = m;
    it.step_time = dt;
    return it;
  endfunction

  // extremes, small speeds near zero, or anything
  function automatic logic [15:0] rand_speed();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3, 4, 5: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // kilohertz loop steps are a few dozen counts, but the full range is legal
  function automatic logic [15:0] rand_step();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(0, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ctl_item_t rand_item();
    return mk_item(1'($urandom), rand_speed(), rand_speed(), rand_speed(), rand_step());
  endfunction

  function automatic logic [15:0] rand_gain();
    int unsigned r;
    r = $urandom_range(0, 5);
    case (r)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 8192));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_limit();
    int unsigned r;
    r = $urandom_range(0, 5);
    case (r)
      0: return 16'h0000;
      1: return OneQ15;
      2: return 16'hFFFF;
      3: return OneQ15 - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly no gap, some short, a few long; now and then a calm stretch with none
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    if (r < 100) return 0;
    if (r < 170) return $urandom_range(1, 3);
    if (r < 194) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < PrintCap) $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // register write; the block is idle whenever this is called
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PROP_GAIN:    kp = val;
      REG_INTEG_GAIN:   ki = val;
      REG_WINDUP_GAIN:  kaw = val;
      REG_FFWD_GAIN:    kff = val;
      REG_THROTTLE_MAX: thr_max = val;
      default: ;
    endcase
  endtask

  // writes every register, then steps to a falling edge so queue pushes stay race free
  task automatic set_gains(logic [15:0] p, logic [15:0] i, logic [15:0] aw,
                           logic [15:0] ff, logic [15:0] lim);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_WINDUP_GAIN, aw);
    write_reg(REG_FFWD_GAIN, ff);
    write_reg(REG_THROTTLE_MAX, lim);
    @(negedge clk_i);
  endtask

  // wait until every item is taken and every command is back, then let the block settle
  task automatic drain();
    while (item_q.size() != 0 || throttle_q.size() != 0 || s_axis_tvalid)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver

  // offers item_q[0]; a beat that is not taken stays on the bus unchanged
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      beats_in      <= 0;
      tx_gap  = 0;
      tx_calm = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        throttle_q.push_back(predict_throttle(item_q.pop_front()));
        beats_in <= beats_in + 1;
        // keep pushing while the receiver is held off, so the block backs up
        tx_gap = rx_hold ? 0 : next_gap(tx_calm);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (item_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {item_q[0].step_time, item_q[0].meas_speed,
                            item_q[0].ref_speed, item_q[0].vel_err};
          s_axis_tuser  <= item_q[0].func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall = 0;
      rx_calm  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (throttle_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing expected", m_axis_tdata));
        end else begin
          want = throttle_q.pop_front();
          if (m_axis_tdata[15:0] !== want.throttle)
            report_mismatch($sformatf("throttle %h, expected %h",
                                      m_axis_tdata[15:0], want.throttle));
          if (m_axis_tdata[17:16] !== want.clamp)
            report_mismatch($sformatf("clamp_state %0d, expected %s",
                                      m_axis_tdata[17:16], want.clamp.name()));
        end
      end
      // random back-pressure on top of the long hold-off
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !rx_hold;
        if ($urandom_range(0, 3) == 0) rx_stall = next_gap(rx_calm);
      end
    end
  end

  // long receiver hold-off, started after a given number of accepted input beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold <= 1'b0;
      hold_left = 0;
      hold_at   = 350;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) rx_hold <= 1'b0;
    end else if (beats_in >= hold_at && hold_at < 2000) begin
      rx_hold <= 1'b1;
      hold_left = HoldCycles;
      hold_at   = hold_at + 800;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset gains: every product vanishes and the command is exactly zero, unclamped;
    // the unused velocity fields carry junk
    item_q.push_back(mk_item(1'b0, 16'h7FFF, 16'h1234, 16'hABCD, 16'hFFFF));
    item_q.push_back(mk_item(1'b1, 16'hC3C3, 16'h8000, 16'h7FFF, 16'hFFFF));
    drain();

    // unit proportional gain, no integral action: an error of 1.0 m/s lands on the limit
    set_gains(16'd4096, 16'd0, 16'd4096, 16'd0, OneQ15);
    item_q.push_back(mk_item(1'b0, 16'd256, 16'h0000, 16'h0000, 16'h0000));
    item_q.push_back(mk_item(1'b0, 16'd257, 16'hFFFF, 16'hFFFF, 16'h0000));
    item_q.push_back(mk_item(1'b0, 16'd0, 16'h0000, 16'h0000, 16'h1000));
    item_q.push_back(mk_item(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    item_q.push_back(mk_item(1'b0, 16'd128, 16'h0000, 16'h0000, 16'h0041));
    item_q.push_back(mk_item(1'b1, 16'h5A5A, 16'd200, 16'd100, 16'h8000));
    drain();

    // feed-forward with a limit above one, which must act as one
    set_gains(16'd4096, 16'd0, 16'd4096, 16'd4096, 16'hFFFF);
    item_q.push_back(mk_item(1'b1, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h0040));
    item_q.push_back(mk_item(1'b1, 16'hFFFF, 16'h0040, 16'h0040, 16'h0040));
    item_q.push_back(mk_item(1'b1, 16'h0000, 16'h8000, 16'h8000, 16'h0040));
    drain();

    // zero limit: any positive command clamps high at zero, exactly zero does not clamp
    set_gains(16'd4096, 16'd0, 16'd4096, 16'd0, 16'd0);
    item_q.push_back(mk_item(1'b0, 16'd1, 16'h0000, 16'h0000, 16'h0000));
    item_q.push_back(mk_item(1'b0, 16'd0, 16'h0000, 16'h0000, 16'h0000));
    item_q.push_back(mk_item(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    drain();

    // full gains and full-scale errors drive the integrator into both rails
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, OneQ15);
    item_q.push_back(mk_item(1'b1, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF));
    item_q.push_back(mk_item(1'b1, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF));
    item_q.push_back(mk_item(1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF));
    item_q.push_back(mk_item(1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF));
    item_q.push_back(mk_item(1'b0, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF));
    item_q.push_back(mk_item(1'b0, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF));
    drain();

    // random settings, each followed by a batch of random updates
    for (int p = 0; p < RandPhases; p++) begin
      set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_limit());
      for (int n = 0; n < PhaseItems; n++) item_q.push_back(rand_item());
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
